FILE: rtl/core/acpu_pkg.sv
// Shared types, codes and field widths of the accumulator machine execute unit.
package acpu_pkg;

	localparam int DATA_W = 32;
	localparam int PC_W   = 10;
	localparam int OP_W   = 4;
	localparam int EV_W   = 3;
	localparam int VIDX_W = 5;
	localparam int TL_W   = 9;
	localparam int TICK_W = 2;

	// Stream payload widths; the tdata widths are whole bytes, the tuser widths are not padded.
	localparam int S_TDATA_W = 112;
	localparam int S_TUSER_W = 6;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = EV_W;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 4'd0,
		OP_STORE   = 4'd1,
		OP_ADD     = 4'd2,
		OP_SUB     = 4'd3,
		OP_MULT    = 4'd4,
		OP_DIV     = 4'd5,
		OP_BRANY   = 4'd6,
		OP_BRPOS   = 4'd7,
		OP_BRZERO  = 4'd8,
		OP_BRNEG   = 4'd9,
		OP_SYSCALL = 4'd10
	} op_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE     = 3'd0,
		EV_FINISHED = 3'd1,
		EV_PRINT    = 3'd2,
		EV_INPUT    = 3'd3,
		EV_DIV_ZERO = 3'd4
	} ev_t;

	localparam logic [DATA_W-1:0] SYS_EXIT  = 32'd0;
	localparam logic [DATA_W-1:0] SYS_PRINT = 32'd1;
	localparam logic [DATA_W-1:0] SYS_INPUT = 32'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OPER,
		ST_DIV,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/core/accumulator_cpu_execute.sv
// Top level of the accumulator machine execute unit: sequencer, state registers, store and divider.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  one decoded instruction
//  m_*      out        m_tvalid/m_tready  accumulator, program counter, event, block time
//
// From acceptance to its result an instruction passes these steps: accept and read the
// variable store, form the operand, execute. DIV with a non-zero divisor adds a wait for
// the bit-serial divider between operand formation and execute, so it is the slowest.
// After reset a clearing pass zeroes every entry of the variable store; no item is
// accepted until it ends. A result waiting in the output register does not stop the next
// item being accepted; only the execute step waits for the output register to empty.
module accumulator_cpu_execute #(
	parameter int VARIABLES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// immediate[31:0], var_index[36:32], target_line[45:37], input_value[77:46],
	// block_ticks[79:78], global_time[111:80]
	input  logic [acpu_pkg::S_TDATA_W-1:0]   s_tdata,
	// action[3:0], use_immediate[4], var_found[5]
	input  logic [acpu_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// acc_out[31:0], pc_out[41:32], blocked_until[73:42], zero padding[79:74]
	output logic [acpu_pkg::M_TDATA_W-1:0]   m_tdata,
	// event_res[2:0]
	output logic [acpu_pkg::M_TUSER_W-1:0]   m_tuser
);
	import acpu_pkg::*;

	localparam int AW = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;

	// Input fields as they arrive.
	logic [OP_W-1:0]   in_action;
	logic              in_use_imm;
	logic              in_found;
	logic [DATA_W-1:0] in_imm;
	logic [VIDX_W-1:0] in_vidx;
	logic [TL_W-1:0]   in_target;
	logic [DATA_W-1:0] in_input;
	logic [TICK_W-1:0] in_ticks;
	logic [DATA_W-1:0] in_gtime;

	assign in_action  = s_tuser[3:0];
	assign in_use_imm = s_tuser[4];
	assign in_found   = s_tuser[5];
	assign in_imm     = s_tdata[31:0];
	assign in_vidx    = s_tdata[36:32];
	assign in_target  = s_tdata[45:37];
	assign in_input   = s_tdata[77:46];
	assign in_ticks   = s_tdata[79:78];
	assign in_gtime   = s_tdata[111:80];

	// The instruction held while it is worked on.
	logic [OP_W-1:0]   action_q;
	logic              use_imm_q;
	logic              found_q;
	logic [DATA_W-1:0] imm_q;
	logic [VIDX_W-1:0] vidx_q;
	logic [TL_W-1:0]   target_q;
	logic [DATA_W-1:0] input_q;
	logic [TICK_W-1:0] ticks_q;
	logic [DATA_W-1:0] gtime_q;
	logic [DATA_W-1:0] operand_q;

	// Architectural state. The accumulator and program counter also drive the output
	// payload directly: they only change at the execute step, which waits until the
	// previous result has been taken.
	logic [DATA_W-1:0] acc_q;
	logic [PC_W-1:0]   pc_q;
	logic [EV_W-1:0]   ev_q;
	logic [DATA_W-1:0] until_q;
	logic              m_tvalid_q;

	state_t state_q, state_nx;
	logic [AW-1:0] clr_q;

	logic              accept;
	logic              finish;
	logic              var_ok;
	logic [DATA_W-1:0] operand;
	logic [DATA_W-1:0] ram_rdata;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [AW-1:0]     vaddr_q;
	logic              div_start;
	div_stat_t         div_stat;
	logic [DATA_W-1:0] div_quo;

	logic [DATA_W-1:0] acc_nx;
	logic [PC_W-1:0]   pc_nx;
	logic [EV_W-1:0]   ev_nx;
	logic [DATA_W-1:0] until_nx;
	logic              store_we;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign finish   = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	// Store addresses are the low bits of the index; indexes beyond the store are caught
	// by var_ok before they are used.
	assign ram_raddr = AW'({{AW{1'b0}}, in_vidx});
	assign vaddr_q   = AW'({{AW{1'b0}}, vidx_q});
	assign var_ok    = found_q && ({{(32-VIDX_W){1'b0}}, vidx_q} < 32'(VARIABLES));
	assign operand   = use_imm_q ? imm_q : (var_ok ? ram_rdata : '0);

	// Write port is shared between the clearing pass and STORE. A STORE is written at
	// the execute step, and the next read is only issued when the following item is
	// accepted, so the two never touch the same entry in one cycle.
	assign ram_we    = (state_q == ST_CLEAR) || (finish && store_we);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : vaddr_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : acc_q;

	acpu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (VARIABLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// DIV by a non-zero operand starts the divider straight from the immediate or the store output.
	assign div_start = (state_q == ST_OPER) && (op_t'(action_q) == OP_DIV) && (operand != '0);

	acpu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (operand),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(VARIABLES - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_OPER;
				end
			end
			ST_OPER: begin
				state_nx = div_start ? ST_DIV : ST_EXEC;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (finish) begin
					state_nx = ST_IDLE;
				end
			end
		endcase
	end

	// Execute step: the new state and the result of the held instruction.
	always_comb begin
		logic [PC_W-1:0] next_pc;
		logic [PC_W-1:0] target;
		logic            acc_neg;
		logic            acc_zero;
		next_pc  = pc_q + 1'b1;
		target   = {target_q[TL_W-1], target_q};
		acc_neg  = acc_q[DATA_W-1];
		acc_zero = (acc_q == '0);
		acc_nx   = acc_q;
		pc_nx    = next_pc;
		ev_nx    = EV_NONE;
		until_nx = '0;
		store_we = 1'b0;
		unique case (op_t'(action_q))
			OP_LOAD:   acc_nx = operand_q;
			OP_STORE:  store_we = var_ok;
			OP_ADD:    acc_nx = acc_q + operand_q;
			OP_SUB:    acc_nx = acc_q - operand_q;
			OP_MULT:   acc_nx = acc_q * operand_q;
			OP_DIV: begin
				if (operand_q != '0) begin
					acc_nx = div_quo;
				end else begin
					ev_nx = EV_DIV_ZERO;
				end
			end
			OP_BRANY:  pc_nx = target;
			OP_BRPOS:  pc_nx = (!acc_neg && !acc_zero) ? target : next_pc;
			OP_BRZERO: pc_nx = acc_zero ? target : next_pc;
			OP_BRNEG:  pc_nx = acc_neg ? target : next_pc;
			OP_SYSCALL: begin
				if (imm_q == SYS_EXIT) begin
					ev_nx = EV_FINISHED;
				end else if (imm_q == SYS_PRINT) begin
					ev_nx    = EV_PRINT;
					until_nx = gtime_q + {{(DATA_W-TICK_W){1'b0}}, ticks_q};
				end else if (imm_q == SYS_INPUT) begin
					acc_nx   = input_q;
					ev_nx    = EV_INPUT;
					until_nx = gtime_q + {{(DATA_W-TICK_W){1'b0}}, ticks_q};
				end
			end
			default: pc_nx = pc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pc_q       <= '0;
			m_tvalid_q <= 1'b0;
			clr_q      <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (finish) begin
				acc_q      <= acc_nx;
				pc_q       <= pc_nx;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= in_action;
			use_imm_q <= in_use_imm;
			found_q   <= in_found;
			imm_q     <= in_imm;
			vidx_q    <= in_vidx;
			target_q  <= in_target;
			input_q   <= in_input;
			ticks_q   <= in_ticks;
			gtime_q   <= in_gtime;
		end
		if (state_q == ST_OPER) begin
			operand_q <= operand;
		end
		if (finish) begin
			ev_q    <= ev_nx;
			until_q <= until_nx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-2*DATA_W-PC_W){1'b0}}, until_q, pc_q, acc_q};
	assign m_tuser  = ev_q;

	// The divider only reports completion while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide wait");

	// The divide wait is only entered with a non-zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> operand_q != '0)
		else $error("divide started with a zero divisor");

	// An accepted item always moves on to operand formation.
	a_accept_oper: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_OPER)
		else $error("accepted item did not proceed");

	// The store is written only by the clearing pass or at the execute step.
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_EXEC))
		else $error("store written outside clear or execute");

endmodule

FILE: rtl/core/acpu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module acpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/acpu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module acpu_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [acpu_pkg::DATA_W-1:0]   dividend,
	input  logic [acpu_pkg::DATA_W-1:0]   divisor,
	output acpu_pkg::div_stat_t           stat,
	output logic [acpu_pkg::DATA_W-1:0]   quotient
);
	import acpu_pkg::*;

	localparam int CW = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   rem_sh;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Magnitudes are taken at start; the most negative value maps onto its own bit pattern,
	// which is the correct unsigned magnitude.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			quo_q <= dividend[DATA_W-1] ? -dividend : dividend;
			dvs_q <= divisor[DATA_W-1] ? -divisor : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= DATA_W'(rem_sh - {1'b0, dvs_q});
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? -quo_q : quo_q;

endmodule

FILE: tb/sv/accumulator_cpu_execute_tb.sv
// Self-checking stream testbench for the accumulator machine execute unit.
`timescale 1ns / 100ps

module accumulator_cpu_execute_tb;
	import acpu_pkg::*;

	// Clock and reset timing.
	localparam int RESET_CYCLES = 9;

	// The slowest instruction is a DIV. The tail wait covers a few of those, and
	// the watchdog allows for the clearing pass, the long receiver hold-off and the slowest
	// stall patterns several times over.
	localparam int TAIL_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 600;
	localparam int MAX_REPORTS    = 10;

	// Action codes that the package leaves unused; the block must ignore them.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd11;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	// Word extremes used by the directed tests.
	localparam logic [DATA_W-1:0] MIN_WORD  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MAX_WORD  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

	// A branch target of all ones means the label was not resolved (line -1).
	localparam logic [TL_W-1:0] TARGET_NONE = 9'h1FF;
	localparam logic [TL_W-1:0] TARGET_LOW  = 9'h100;

	// One decoded instruction as it travels on the input stream.
	typedef struct packed {
		logic [OP_W-1:0]   action;
		logic              use_imm;
		logic [DATA_W-1:0] imm;
		logic [VIDX_W-1:0] vidx;
		logic              found;
		logic [TL_W-1:0]   target;
		logic [DATA_W-1:0] input_value;
		logic [TICK_W-1:0] ticks;
		logic [DATA_W-1:0] gtime;
	} instr_t;

	// One architectural result as it leaves on the output stream.
	typedef struct packed {
		logic [DATA_W-1:0] acc;
		logic [PC_W-1:0]   pc;
		logic [EV_W-1:0]   ev;
		logic [DATA_W-1:0] wake_at;
	} result_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// immediate, var_index, target_line, input_value, block_ticks, global_time
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	// action, use_immediate, var_found
	logic [S_TUSER_W-1:0]   s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// acc_out, pc_out, blocked_until, zero padding
	logic [M_TDATA_W-1:0]   m_tdata;
	// event_res
	logic [M_TUSER_W-1:0]   m_tuser;

	// Architectural state as the testbench believes it to be after every accepted item.
	logic [DATA_W-1:0] acc_shadow = '0;
	logic [PC_W-1:0]   pc_shadow  = '0;
	logic [DATA_W-1:0] vars_shadow [32];

	// Results still owed by the block, oldest first.
	result_t pending_results [$];

	int mismatches    = 0;
	int quiet_cycles  = 0;
	int burst_left    = 0;
	int hold_request  = 0;
	int pattern_age   = 0;
	logic [15:0] ready_pattern = '1;

	result_t got_result;
	result_t want_result;

	always #1 clk = ~clk;

	accumulator_cpu_execute u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		for (int i = 0; i < 32; i++)
			vars_shadow[i] = '0;
	end

	// Applies one instruction to the shadow state and returns the result the block owes for it.
	function automatic result_t retire_instr(instr_t it);
		logic [DATA_W-1:0] var_val;
		logic [DATA_W-1:0] operand;
		logic [PC_W-1:0]   target;
		logic [PC_W-1:0]   next_pc;
		longint            quotient;
		result_t           r;

		var_val   = it.found ? vars_shadow[it.vidx] : '0;
		operand   = it.use_imm ? it.imm : var_val;
		target    = {it.target[TL_W-1], it.target};
		next_pc   = pc_shadow + 10'd1;
		r.ev      = EV_NONE;
		r.wake_at = '0;

		case (it.action)
			OP_LOAD: begin
				acc_shadow = operand;
				pc_shadow  = next_pc;
			end
			OP_STORE: begin
				if (it.found)
					vars_shadow[it.vidx] = acc_shadow;
				pc_shadow = next_pc;
			end
			OP_ADD: begin
				acc_shadow = acc_shadow + operand;
				pc_shadow  = next_pc;
			end
			OP_SUB: begin
				acc_shadow = acc_shadow - operand;
				pc_shadow  = next_pc;
			end
			OP_MULT: begin
				acc_shadow = acc_shadow * operand;
				pc_shadow  = next_pc;
			end
			OP_DIV: begin
				// Worked in 64 bits so that the most negative word over minus one simply wraps.
				if (operand != '0) begin
					quotient   = longint'($signed(acc_shadow)) / longint'($signed(operand));
					acc_shadow = quotient[DATA_W-1:0];
				end else begin
					r.ev = EV_DIV_ZERO;
				end
				pc_shadow = next_pc;
			end
			OP_BRANY:   pc_shadow = target;
			OP_BRPOS:   pc_shadow = (!acc_shadow[DATA_W-1] && acc_shadow != '0) ? target : next_pc;
			OP_BRZERO:  pc_shadow = (acc_shadow == '0) ? target : next_pc;
			OP_BRNEG:   pc_shadow = acc_shadow[DATA_W-1] ? target : next_pc;
			OP_SYSCALL: begin
				if (it.imm == SYS_EXIT) begin
					r.ev = EV_FINISHED;
				end else if (it.imm == SYS_PRINT) begin
					r.ev      = EV_PRINT;
					r.wake_at = it.gtime + {{(DATA_W-TICK_W){1'b0}}, it.ticks};
				end else if (it.imm == SYS_INPUT) begin
					acc_shadow = it.input_value;
					r.ev       = EV_INPUT;
					r.wake_at  = it.gtime + {{(DATA_W-TICK_W){1'b0}}, it.ticks};
				end
				pc_shadow = next_pc;
			end
			default: ;
		endcase

		r.acc = acc_shadow;
		r.pc  = pc_shadow;
		return r;
	endfunction

	// Every field drawn over its whole range; the directed tests overwrite what they care about.
	function automatic instr_t random_instr();
		instr_t it;

		it.action      = OP_W'($urandom_range(0, 15));
		it.use_imm     = 1'($urandom_range(0, 1));
		it.imm         = $urandom;
		it.vidx        = VIDX_W'($urandom_range(0, 31));
		it.found       = 1'($urandom_range(0, 1));
		it.target      = TL_W'($urandom_range(0, 511));
		it.input_value = $urandom;
		it.ticks       = TICK_W'($urandom_range(0, 3));
		it.gtime       = $urandom;
		return it;
	endfunction

	// Operand values weighted towards the corners of signed arithmetic.
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return MIN_WORD;
			1:       return MAX_WORD;
			2:       return '0;
			3:       return ALL_ONES;
			4, 5:    return int'($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Instruction mix resembling a running program: mostly arithmetic on a handful of
	// variables, so that stores are read back, with branches, system calls and a little noise.
	function automatic instr_t shaped_instr();
		instr_t it;
		int     pick;

		it   = random_instr();
		pick = $urandom_range(0, 99);
		if (pick < 14)
			it.action = OP_LOAD;
		else if (pick < 26)
			it.action = OP_STORE;
		else if (pick < 40)
			it.action = OP_ADD;
		else if (pick < 50)
			it.action = OP_SUB;
		else if (pick < 60)
			it.action = OP_MULT;
		else if (pick < 72)
			it.action = OP_DIV;
		else if (pick < 86)
			it.action = OP_W'($urandom_range(OP_BRANY, OP_BRNEG));
		else if (pick < 97)
			it.action = OP_SYSCALL;
		else
			it.action = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

		it.imm   = pick_word();
		it.vidx  = ($urandom_range(0, 3) != 0) ? VIDX_W'($urandom_range(0, 7)) :
			VIDX_W'($urandom_range(0, 31));
		it.found = ($urandom_range(0, 7) != 0);
		if (it.action == OP_SYSCALL && $urandom_range(0, 5) != 0)
			it.imm = $urandom_range(SYS_EXIT, SYS_INPUT);
		if ($urandom_range(0, 3) == 0)
			it.gtime = ALL_ONES - $urandom_range(0, 3);
		return it;
	endfunction

	// Offers one item on the input stream and waits until it is taken. The sender works in
	// bursts; between bursts it sometimes drops tvalid for a random number of cycles.
	task automatic send_instr(instr_t it);
		int gap;

		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
			case ($urandom_range(0, 7))
				0, 1, 2: gap = 0;
				3, 4, 5: gap = $urandom_range(1, 4);
				6:       gap = $urandom_range(5, 12);
				default: gap = $urandom_range(13, 30);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;

		s_tvalid <= 1'b1;
		s_tdata  <= {it.gtime, it.ticks, it.input_value, it.target, it.vidx, it.imm};
		s_tuser  <= {it.found, it.use_imm, it.action};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);

		// The item was taken at this edge; its result can only appear after operand formation and execute.
		pending_results.push_back(retire_instr(it));
	endtask

	task automatic issue_data(logic [OP_W-1:0] action, logic use_imm, logic [DATA_W-1:0] imm,
			logic [VIDX_W-1:0] vidx, logic found);
		instr_t it;

		it         = random_instr();
		it.action  = action;
		it.use_imm = use_imm;
		it.imm     = imm;
		it.vidx    = vidx;
		it.found   = found;
		send_instr(it);
	endtask

	task automatic issue_branch(logic [OP_W-1:0] action, logic [TL_W-1:0] target);
		instr_t it;

		it        = random_instr();
		it.action = action;
		it.target = target;
		send_instr(it);
	endtask

	task automatic issue_syscall(logic [DATA_W-1:0] num, logic [TICK_W-1:0] ticks,
			logic [DATA_W-1:0] gtime, logic [DATA_W-1:0] value);
		instr_t it;

		it             = random_instr();
		it.action      = OP_SYSCALL;
		it.imm         = num;
		it.ticks       = ticks;
		it.gtime       = gtime;
		it.input_value = value;
		send_instr(it);
	endtask

	// Loads and stores at the top entry and a low entry of the store, including missing
	// variables, which read as zero and swallow stores.
	task automatic test_load_store();
		issue_data(OP_LOAD, 1'b1, MIN_WORD, 5'd0, 1'b0);
		issue_data(OP_STORE, 1'b0, $urandom, 5'd31, 1'b1);
		issue_data(OP_LOAD, 1'b1, MAX_WORD, 5'd0, 1'b0);
		issue_data(OP_STORE, 1'b0, $urandom, 5'd3, 1'b0);
		issue_data(OP_LOAD, 1'b0, $urandom, 5'd31, 1'b0);
		issue_data(OP_LOAD, 1'b0, $urandom, 5'd3, 1'b1);
		issue_data(OP_LOAD, 1'b0, $urandom, 5'd31, 1'b1);
	endtask

	// The accumulator now holds the most negative word. Dividing it by minus one must wrap to
	// itself; the chain then wraps ADD, MULT and SUB, truncates a negative quotient towards
	// zero and tries both kinds of zero divisor.
	task automatic test_arithmetic();
		issue_data(OP_DIV, 1'b1, ALL_ONES, 5'd0, 1'b0);
		issue_data(OP_ADD, 1'b1, ALL_ONES, 5'd0, 1'b0);
		issue_data(OP_MULT, 1'b1, 32'd3, 5'd0, 1'b0);
		issue_data(OP_SUB, 1'b1, MIN_WORD, 5'd0, 1'b0);
		issue_data(OP_DIV, 1'b1, 32'd2, 5'd0, 1'b0);
		issue_data(OP_DIV, 1'b1, '0, 5'd0, 1'b0);
		issue_data(OP_DIV, 1'b0, $urandom, 5'd7, 1'b1);
	endtask

	// The accumulator is negative here. An unresolved target takes the counter to -1, from where
	// the next advance wraps it to zero; the far negative target lands in the upper half.
	task automatic test_branches();
		issue_branch(OP_BRPOS, 9'd5);
		issue_branch(OP_BRNEG, TARGET_NONE);
		issue_data(OP_ADD, 1'b1, 32'd1, 5'd0, 1'b0);
		issue_branch(OP_BRZERO, 9'd255);
		issue_branch(OP_BRPOS, 9'd9);
		issue_branch(OP_BRNEG, 9'd17);
		issue_branch(OP_BRANY, TARGET_LOW);
	endtask

	// Finish, and print and input at the wrap of the global time, with zero and full block ticks,
	// an unknown system call number and an unused action code.
	task automatic test_syscalls();
		issue_syscall(SYS_EXIT, 2'd1, $urandom, $urandom);
		issue_syscall(SYS_PRINT, 2'd0, ALL_ONES, $urandom);
		issue_syscall(SYS_INPUT, 2'd3, ALL_ONES, MIN_WORD);
		issue_syscall(SYS_INPUT + 32'd1, 2'd2, $urandom, $urandom);
		issue_data(OP_SPARE_HI, 1'b1, $urandom, 5'd1, 1'b1);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering a dense burst,
	// so the output register fills and the block has to stall its input.
	task automatic test_output_backpressure();
		hold_request = HOLD_CYCLES;
		burst_left   = 24;
		repeat (24) send_instr(shaped_instr());
	endtask

	task automatic test_random_program();
		repeat (RANDOM_ITEMS) send_instr(shaped_instr());
	endtask

	// The receiver follows a rotating ready pattern, redrawn whenever pattern_age runs out:
	// sometimes always ready, sometimes mostly stalled. A hold-off request overrides it.
	initial begin : receiver
		int hold_len;

		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_len     = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
			end else begin
				if (pattern_age == 0) begin
					pattern_age = 32;
					case ($urandom_range(0, 3))
						0:       ready_pattern = '1;
						1:       ready_pattern = 16'($urandom);
						2:       ready_pattern = 16'($urandom & $urandom);
						default: ready_pattern = 16'($urandom | $urandom);
					endcase
				end
				pattern_age--;
				m_tready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			end
		end
	end

	// Each result taken from the output stream is held against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result.acc     = m_tdata[31:0];
			got_result.pc      = m_tdata[41:32];
			got_result.wake_at = m_tdata[73:42];
			got_result.ev      = m_tuser;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: acc %h pc %h ev %0d blocked %h",
						got_result.acc, got_result.pc, got_result.ev, got_result.wake_at);
			end else begin
				want_result = pending_results.pop_front();
				if (got_result.acc !== want_result.acc || got_result.pc !== want_result.pc ||
						got_result.ev !== want_result.ev ||
						got_result.wake_at !== want_result.wake_at) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result mismatch: expected acc %h pc %h ev %0d blocked %h, %s",
							want_result.acc, want_result.pc, want_result.ev,
							want_result.wake_at,
							$sformatf("got acc %h pc %h ev %0d blocked %h", got_result.acc,
								got_result.pc, got_result.ev, got_result.wake_at));
				end
			end
		end
	end

	// Ends the run if neither stream moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("accumulator_cpu_execute_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_load_store();
		test_arithmetic();
		test_branches();
		test_syscalls();
		test_output_backpressure();
		test_random_program();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("accumulator_cpu_execute_tb: clean");
		else
			$display("accumulator_cpu_execute_tb: errors");
		$finish;
	end

endmodule
